[rtl/core/reb_pkg.sv]
`default_nettype none

package reb_pkg;

   // Field and register widths.
   localparam int COUNT_WIDTH     = 16;
   localparam int TIME_WIDTH      = 32;
   localparam int DIVISOR_WIDTH   = 5;
   localparam int EVENT_WIDTH     = 2;
   localparam int STEP_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int DEBOUNCE_WIDTH  = 16;
   localparam int LONG_WIDTH      = 16;

   // Signed detents times the divisor, with room for the sign of the divisor operand.
   localparam int PROD_WIDTH = STEP_WIDTH + DIVISOR_WIDTH + 1;

   // Iteration counter of the bit-serial divider.
   localparam int ITER_WIDTH = $clog2(COUNT_WIDTH);
   localparam int ITER_LAST  = COUNT_WIDTH - 1;

   // Saturation limits of the detent count.
   localparam int STEP_POS_LIMIT = (1 << (STEP_WIDTH - 1)) - 1;
   localparam int STEP_NEG_LIMIT = 1 << (STEP_WIDTH - 1);

   // Register reset values.
   localparam int RESET_COUNTS_PER_DETENT = 4;
   localparam int RESET_DEBOUNCE_TIME     = 20;
   localparam int RESET_LONG_PRESS_TIME   = 1000;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTS_PER_DETENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TIME     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TIME   = 2'd2;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_NONE    = 2'd0,
      EV_ROTATED = 2'd1,
      EV_SHORT   = 2'd2,
      EV_LONG    = 2'd3
   } event_kind_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [TIME_WIDTH-1:0]  time_type;

endpackage

`default_nettype wire

[rtl/core/reb_div.sv]
`default_nettype none

module reb_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [reb_pkg::COUNT_WIDTH-1:0]      dividend,
   input  logic [reb_pkg::DIVISOR_WIDTH-1:0]    divisor,
   output logic [reb_pkg::COUNT_WIDTH-1:0]      quotient,
   output logic                                 done
);
   import reb_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [ITER_WIDTH-1:0]     iter_ff, iter_in;
   logic [COUNT_WIDTH-1:0]    quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    trial_diff;
   logic                      fits;

   // One restoring step: bring down the next dividend bit and try the subtraction.
   always_comb begin
      trial      = {rem_ff, quo_ff[COUNT_WIDTH-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});
   end

   // Sequencing: load on start, then one quotient bit per cycle.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         iter_in    = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[COUNT_WIDTH-2:0], fits};
         rem_in  = fits ? trial_diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_WIDTH'(ITER_LAST)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff    <= iter_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

[rtl/core/rotary_encoder_button_events_core.sv]
// A rotation request passes the divide, apply and done states; a button request also passes debounce and long-press.
// The divider is bit-serial, one quotient bit per cycle.
// One request is in flight at a time; a finished result waits in the output register.
// Reset (synchronous, active high) restores the register defaults and the tracking state:
// consumed count zero, button released, timestamps zero, no long press reported.
`default_nettype none

module rotary_encoder_button_events_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [reb_pkg::COUNT_WIDTH-1:0]   req_encoder_count,
   input  logic                                     req_button_raw,
   input  logic [reb_pkg::TIME_WIDTH-1:0]           req_now_ms,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [reb_pkg::EVENT_WIDTH-1:0]          rsp_event_kind,
   output logic signed [reb_pkg::STEP_WIDTH-1:0]    rsp_detent_steps,
   input  logic                                     csr_write,
   input  logic [reb_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [reb_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);
   import reb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY,
      ST_DEBOUNCE,
      ST_LONG,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [DIVISOR_WIDTH-1:0]  cpd_ff, cpd_in;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;
   logic [LONG_WIDTH-1:0]     long_time_ff, long_time_in;

   // Sequencer and request state.
   state_type                 state_ff, state_in;
   logic                      raw_ff, raw_in;
   time_type                  now_ff, now_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic                      negative_ff, negative_in;
   logic signed [STEP_WIDTH-1:0] det_ff, det_in;
   event_kind_type            kind_ff, kind_in;

   // Tracking state.
   count_type                 consumed_ff, consumed_in;
   logic                      stable_ff, stable_in;
   logic                      previous_ff, previous_in;
   time_type                  change_ff, change_in;
   time_type                  press_ff, press_in;
   logic                      long_ff, long_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   event_kind_type            rsp_kind_ff, rsp_kind_in;
   logic signed [STEP_WIDTH-1:0] rsp_steps_ff, rsp_steps_in;

   // Datapath.
   logic                      req_accept;
   logic [DIVISOR_WIDTH-1:0]  divisor_eff;
   count_type                 delta;
   logic                      delta_negative;
   count_type                 delta_mag;
   count_type                 div_quotient;
   logic                      div_done;
   logic [STEP_WIDTH-1:0]     det_sat;
   logic signed [PROD_WIDTH-1:0] product;
   time_type                  since_change;
   time_type                  since_press;
   logic                      debounce_elapsed;
   logic                      long_elapsed;
   logic                      stable_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Configuration writes; an index beyond the list is ignored.
   always_comb begin
      cpd_in       = cpd_ff;
      debounce_in  = debounce_ff;
      long_time_in = long_time_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COUNTS_PER_DETENT: cpd_in       = csr_data[DIVISOR_WIDTH-1:0];
            CSR_DEBOUNCE_TIME:     debounce_in  = csr_data[DEBOUNCE_WIDTH-1:0];
            CSR_LONG_PRESS_TIME:   long_time_in = csr_data[LONG_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Signed count difference, split into sign and magnitude for the divider.
   always_comb begin
      divisor_eff    = (cpd_ff == '0) ? DIVISOR_WIDTH'(1) : cpd_ff;
      delta          = count_type'(req_encoder_count) - consumed_ff;
      delta_negative = delta[COUNT_WIDTH-1];
      delta_mag      = delta_negative ? (~delta + 1'b1) : delta;
   end

   reb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .dividend (delta_mag),
      .divisor  (divisor_eff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // Restore the sign of the quotient and clamp it to the detent range.
   always_comb begin
      if (!negative_ff) begin
         det_sat = (div_quotient > COUNT_WIDTH'(STEP_POS_LIMIT)) ?
                   STEP_WIDTH'(STEP_POS_LIMIT) : div_quotient[STEP_WIDTH-1:0];
      end else begin
         det_sat = (div_quotient > COUNT_WIDTH'(STEP_NEG_LIMIT)) ?
                   STEP_WIDTH'(STEP_NEG_LIMIT) :
                   (~div_quotient[STEP_WIDTH-1:0] + 1'b1);
      end
   end

   // Counts consumed by a rotation: detents times the divisor.
   assign product = det_ff * $signed({1'b0, divisor_ff});

   // Elapsed times, wrapping with the timestamp.
   always_comb begin
      since_change     = now_ff - change_ff;
      since_press      = now_ff - press_ff;
      debounce_elapsed = (since_change >= TIME_WIDTH'(debounce_ff));
      long_elapsed     = (since_press >= TIME_WIDTH'(long_time_ff));
      stable_next      = (raw_ff != stable_ff && debounce_elapsed) ? raw_ff : stable_ff;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      now_in       = now_ff;
      divisor_in   = divisor_ff;
      negative_in  = negative_ff;
      det_in       = det_ff;
      kind_in      = kind_ff;
      consumed_in  = consumed_ff;
      stable_in    = stable_ff;
      previous_in  = previous_ff;
      change_in    = change_ff;
      press_in     = press_ff;
      long_in      = long_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_steps_in = rsp_steps_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               raw_in      = req_button_raw;
               now_in      = req_now_ms;
               divisor_in  = divisor_eff;
               negative_in = delta_negative;
               state_in    = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            if (div_done) begin
               det_in   = $signed(det_sat);
               state_in = ST_APPLY;
            end
         end

         // A rotation consumes its counts and skips the button for this request.
         ST_APPLY: begin
            if (det_ff != '0) begin
               consumed_in = consumed_ff + COUNT_WIDTH'(product);
               kind_in     = EV_ROTATED;
               state_in    = ST_DONE;
            end else begin
               kind_in  = EV_NONE;
               state_in = ST_DEBOUNCE;
            end
         end

         // Debounce by time, then report a release as a short press.
         ST_DEBOUNCE: begin
            stable_in = stable_next;
            if (raw_ff != stable_ff) begin
               if (debounce_elapsed) begin
                  change_in = now_ff;
                  if (!raw_ff) begin
                     press_in = now_ff;
                     long_in  = 1'b0;
                  end
               end
            end else begin
               change_in = now_ff;
            end
            if (stable_next != previous_ff) begin
               previous_in = stable_next;
               if (stable_next && !long_ff) begin
                  kind_in = EV_SHORT;
               end
            end
            state_in = ST_LONG;
         end

         // One long press per hold.
         ST_LONG: begin
            if (!stable_ff && !long_ff && long_elapsed) begin
               long_in = 1'b1;
               kind_in = EV_LONG;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_steps_in = det_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpd_ff       <= DIVISOR_WIDTH'(RESET_COUNTS_PER_DETENT);
         debounce_ff  <= DEBOUNCE_WIDTH'(RESET_DEBOUNCE_TIME);
         long_time_ff <= LONG_WIDTH'(RESET_LONG_PRESS_TIME);
         state_ff     <= ST_IDLE;
         consumed_ff  <= '0;
         stable_ff    <= 1'b1;
         previous_ff  <= 1'b1;
         change_ff    <= '0;
         press_ff     <= '0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cpd_ff       <= cpd_in;
         debounce_ff  <= debounce_in;
         long_time_ff <= long_time_in;
         state_ff     <= state_in;
         consumed_ff  <= consumed_in;
         stable_ff    <= stable_in;
         previous_ff  <= previous_in;
         change_ff    <= change_in;
         press_ff     <= press_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff       <= raw_in;
      now_ff       <= now_in;
      divisor_ff   <= divisor_in;
      negative_ff  <= negative_in;
      det_ff       <= det_in;
      kind_ff      <= kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_steps_ff <= rsp_steps_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_detent_steps = rsp_steps_ff;

`ifndef SYNTHESIS
   // A rotation always carries detents; every other event carries none.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_kind == EV_ROTATED) == (rsp_detent_steps != '0)))
      else $error("detent steps disagree with event kind");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   // An accepted request blocks the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted while another is in flight");

   // A long press is only recorded by the long-press step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(long_ff) |-> $past(state_ff == ST_LONG))
      else $error("long press flag set outside the long-press step");
`endif

endmodule

`default_nettype wire
